// ----- design/ooo_rob_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ooo_rob_pkg;

	localparam int DATA_W           = 32;
	localparam int REG_W            = 3;
	localparam int NUM_REGS         = 2 ** REG_W;
	localparam int MODE_W           = 3;
	localparam int OCC_W            = 3;
	localparam int DEF_NUM_STATIONS = 4;
	localparam int DEF_ROB_DEPTH    = 4;

	typedef enum logic [MODE_W-1:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_LI  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_ISSUED   = 2'd0,
		ST_NONE     = 2'd1,
		ST_ROB_FULL = 2'd2,
		ST_RS_FULL  = 2'd3
	} issue_status_t;

	typedef struct packed {
		logic                     issue_valid;
		logic [MODE_W-1:0]        mode;
		logic [REG_W-1:0]         target_reg;
		logic [REG_W-1:0]         src1_reg;
		logic [REG_W-1:0]         src2_reg;
		logic signed [DATA_W-1:0] immediate;
		logic [REG_W-1:0]         read_reg;
	} req_word_t;

	typedef struct packed {
		logic [1:0]               issue_status;
		logic                     commit_valid;
		logic [REG_W-1:0]         commit_reg;
		logic signed [DATA_W-1:0] commit_value;
		logic signed [DATA_W-1:0] read_value;
		logic [OCC_W-1:0]         rob_occupancy;
	} rsp_word_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ISSUE,
		S_FETCH1,
		S_FETCH2,
		S_ALLOC,
		S_EX_CHECK,
		S_EX_WAIT,
		S_BCAST,
		S_COMMIT
	} ctrl_state_t;

	typedef struct packed {
		logic in_ready;
		logic issue;
		logic fetch1;
		logic fetch2;
		logic alloc;
		logic ex_start;
		logic ex_write;
		logic idx_inc;
		logic idx_clr;
		logic bcast;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic in_fire;
		logic out_busy;
		logic issue_ok;
		logic is_li;
		logic eligible;
		logic alu_done;
		logic idx_last;
		logic half;
	} status_t;

endpackage
`default_nettype wire

// ----- design/ooo_rob_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface ooo_rob_req_if;
	import ooo_rob_pkg::*;
	logic      valid;
	logic      ready;
	req_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/ooo_rob_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface ooo_rob_rsp_if;
	import ooo_rob_pkg::*;
	logic      valid;
	logic      ready;
	rsp_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/ooo_rob_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ooo_rob_alu (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [ooo_rob_pkg::MODE_W-1:0]  op,
	input  wire logic [ooo_rob_pkg::DATA_W-1:0]  a,
	input  wire logic [ooo_rob_pkg::DATA_W-1:0]  b,
	output logic                                 done,
	output logic [ooo_rob_pkg::DATA_W-1:0]       result
);
	import ooo_rob_pkg::*;

	localparam int CNT_W = $clog2(DATA_W);

	logic              busy_q, div_q, done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [MODE_W-1:0] op_q;
	logic [DATA_W-1:0] a_q, b_q, rem_q, quo_q, ub_q, result_q;
	logic              neg_q, zero_q;

	logic [DATA_W-1:0]   ua, ub, rem_sh, rem_nx, quo_nx, simple_res, div_res;
	logic [DATA_W:0]     diff;
	logic [DATA_W-1:0]   prod;
	logic                ge, last;

	assign ua = a[DATA_W-1] ? (~a + 1'b1) : a;
	assign ub = b[DATA_W-1] ? (~b + 1'b1) : b;

	// restoring divide, one quotient bit per clock
	assign rem_sh = {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
	assign diff   = {1'b0, rem_sh} - {1'b0, ub_q};
	assign ge     = ~diff[DATA_W];
	assign rem_nx = ge ? diff[DATA_W-1:0] : rem_sh;
	assign quo_nx = {quo_q[DATA_W-2:0], ge};
	assign last   = (cnt_q == CNT_W'(DATA_W - 1));
	assign div_res = zero_q ? '0 : (neg_q ? (~quo_nx + 1'b1) : quo_nx);

	// low half of the product only
	assign prod = a_q * b_q;

	always_comb begin
		case (op_q)
			OP_ADD:  simple_res = a_q + b_q;
			OP_SUB:  simple_res = a_q - b_q;
			OP_MUL:  simple_res = prod;
			default: simple_res = a_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			div_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				div_q  <= (op == OP_DIV);
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (!div_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
					if (last) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q   <= op;
			a_q    <= a;
			b_q    <= b;
			rem_q  <= '0;
			quo_q  <= ua;
			ub_q   <= ub;
			neg_q  <= a[DATA_W-1] ^ b[DATA_W-1];
			zero_q <= (b == '0);
		end else if (busy_q) begin
			if (!div_q) begin
				result_q <= simple_res;
			end else begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				if (last) begin
					result_q <= div_res;
				end
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;
endmodule
`default_nettype wire

// ----- design/ooo_rob_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ooo_rob_dp #(
	parameter int NUM_STATIONS = ooo_rob_pkg::DEF_NUM_STATIONS,
	parameter int ROB_DEPTH    = ooo_rob_pkg::DEF_ROB_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	ooo_rob_req_if.sink               req,
	ooo_rob_rsp_if.source             rsp,
	input  wire ooo_rob_pkg::cmd_t    cmd,
	output ooo_rob_pkg::status_t      stat
);
	import ooo_rob_pkg::*;

	localparam int TAG_W  = $clog2(ROB_DEPTH);
	localparam int SIDX_W = (NUM_STATIONS > 1) ? $clog2(NUM_STATIONS) : 1;
	localparam int CNT_W  = $clog2(ROB_DEPTH + 1);

	req_word_t         req_q;
	logic [DATA_W-1:0] rf_q [NUM_REGS];

	logic [REG_W-1:0]  rob_dest_q [ROB_DEPTH];
	logic [DATA_W-1:0] rob_val_q  [ROB_DEPTH];
	logic              rob_rdy_q  [ROB_DEPTH];
	logic              rob_busy_q [ROB_DEPTH];
	logic [TAG_W-1:0]  head_q, tail_q;
	logic [CNT_W-1:0]  count_q;

	logic [MODE_W-1:0] st_op_q   [NUM_STATIONS];
	logic [TAG_W-1:0]  st_tag1_q [NUM_STATIONS];
	logic [TAG_W-1:0]  st_tag2_q [NUM_STATIONS];
	logic              st_p1_q   [NUM_STATIONS];
	logic              st_p2_q   [NUM_STATIONS];
	logic [DATA_W-1:0] st_v1_q   [NUM_STATIONS];
	logic [DATA_W-1:0] st_v2_q   [NUM_STATIONS];
	logic [TAG_W-1:0]  st_slot_q [NUM_STATIONS];
	logic              st_busy_q [NUM_STATIONS];

	logic [SIDX_W-1:0] idx_q, sel_st_q;
	logic              half_q;
	logic [1:0]        status_q;
	logic [DATA_W-1:0] rdval_q;
	logic              out_valid_q;
	rsp_word_t         out_q;

	logic              in_fire, out_fire;
	logic              free_found, offered, rob_full, issue_ok;
	logic [SIDX_W-1:0] free_idx;
	logic [1:0]        issue_code;
	logic [REG_W-1:0]  src, rf_ra;
	logic              hit;
	logic [TAG_W-1:0]  hit_idx, rob_ra, tail_nx, head_nx;
	logic [DATA_W-1:0] rob_rd_val, rf_rd, fetch_val;
	logic              rob_rd_rdy, rob_rd_busy, fetch_pend;
	logic              eligible, take, cur_p, c_ok, idx_last;
	logic              alu_done;
	logic [DATA_W-1:0] alu_res;

	assign in_fire  = req.valid & req.ready;
	assign out_fire = rsp.valid & rsp.ready;
	assign req.ready = cmd.in_ready;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_STATIONS - 1; i >= 0; i--) begin
			if (!st_busy_q[i]) begin
				free_found = 1'b1;
				free_idx   = SIDX_W'(i);
			end
		end
	end

	assign offered  = req_q.issue_valid && (req_q.mode <= MODE_W'(OP_LI));
	assign rob_full = (count_q == CNT_W'(ROB_DEPTH));
	assign issue_ok = offered & ~rob_full & free_found;

	always_comb begin
		if (!offered)
			issue_code = ST_NONE;
		else if (rob_full)
			issue_code = ST_ROB_FULL;
		else if (!free_found)
			issue_code = ST_RS_FULL;
		else
			issue_code = ST_ISSUED;
	end

	// youngest in-flight producer of src; oldest scanned first, later hits override
	assign src = cmd.fetch2 ? req_q.src2_reg : req_q.src1_reg;
	always_comb begin
		int t;
		hit     = 1'b0;
		hit_idx = '0;
		for (int k = ROB_DEPTH; k >= 1; k--) begin
			t = int'(tail_q) - k;
			if (t < 0)
				t = t + ROB_DEPTH;
			if ((k <= int'(count_q)) && rob_busy_q[TAG_W'(t)] &&
					(rob_dest_q[TAG_W'(t)] == src)) begin
				hit     = 1'b1;
				hit_idx = TAG_W'(t);
			end
		end
	end

	always_comb begin
		if (cmd.fetch1 || cmd.fetch2)
			rob_ra = hit_idx;
		else if (cmd.bcast)
			rob_ra = half_q ? st_tag2_q[idx_q] : st_tag1_q[idx_q];
		else
			rob_ra = head_q;
	end
	assign rob_rd_val  = rob_val_q[rob_ra];
	assign rob_rd_rdy  = rob_rdy_q[rob_ra];
	assign rob_rd_busy = rob_busy_q[rob_ra];

	assign rf_ra = cmd.issue ? req_q.read_reg : src;
	assign rf_rd = rf_q[rf_ra];

	assign fetch_pend = hit & ~rob_rd_rdy;
	assign fetch_val  = hit ? (rob_rd_rdy ? rob_rd_val : '0) : rf_rd;

	assign eligible = st_busy_q[idx_q] & ~st_p1_q[idx_q] & ~st_p2_q[idx_q];
	assign idx_last = (idx_q == SIDX_W'(NUM_STATIONS - 1));
	assign cur_p    = half_q ? st_p2_q[idx_q] : st_p1_q[idx_q];
	assign take     = st_busy_q[idx_q] & cur_p & rob_rd_busy & rob_rd_rdy;
	assign c_ok     = rob_busy_q[head_q] & rob_rdy_q[head_q];

	assign tail_nx = (tail_q == TAG_W'(ROB_DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign head_nx = (head_q == TAG_W'(ROB_DEPTH - 1)) ? '0 : head_q + 1'b1;

	ooo_rob_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.ex_start & eligible),
		.op     (st_op_q[idx_q]),
		.a      (st_v1_q[idx_q]),
		.b      (st_v2_q[idx_q]),
		.done   (alu_done),
		.result (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				rf_q[i] <= '0;
			for (int i = 0; i < ROB_DEPTH; i++) begin
				rob_rdy_q[i]  <= 1'b0;
				rob_busy_q[i] <= 1'b0;
			end
			for (int i = 0; i < NUM_STATIONS; i++) begin
				st_busy_q[i] <= 1'b0;
				st_p1_q[i]   <= 1'b0;
				st_p2_q[i]   <= 1'b0;
			end
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			half_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_fire)
				out_valid_q <= 1'b0;
			if (cmd.fetch1)
				st_p1_q[sel_st_q] <= fetch_pend;
			if (cmd.fetch2)
				st_p2_q[sel_st_q] <= fetch_pend;
			if (cmd.alloc) begin
				if (req_q.mode == MODE_W'(OP_LI)) begin
					st_p1_q[sel_st_q] <= 1'b0;
					st_p2_q[sel_st_q] <= 1'b0;
				end
				st_busy_q[sel_st_q] <= 1'b1;
				rob_rdy_q[tail_q]   <= 1'b0;
				rob_busy_q[tail_q]  <= 1'b1;
				tail_q              <= tail_nx;
				count_q             <= count_q + 1'b1;
			end
			if (cmd.ex_write) begin
				st_busy_q[idx_q]          <= 1'b0;
				rob_rdy_q[st_slot_q[idx_q]] <= 1'b1;
			end
			if (cmd.bcast) begin
				if (take) begin
					if (half_q)
						st_p2_q[idx_q] <= 1'b0;
					else
						st_p1_q[idx_q] <= 1'b0;
				end
				half_q <= ~half_q;
				if (half_q)
					idx_q <= idx_last ? '0 : idx_q + 1'b1;
			end
			if (cmd.idx_inc)
				idx_q <= idx_q + 1'b1;
			if (cmd.idx_clr) begin
				idx_q  <= '0;
				half_q <= 1'b0;
			end
			if (cmd.commit) begin
				if (c_ok) begin
					rf_q[rob_dest_q[head_q]] <= rob_val_q[head_q];
					rob_busy_q[head_q]       <= 1'b0;
					rob_rdy_q[head_q]        <= 1'b0;
					head_q                   <= head_nx;
					count_q                  <= count_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire)
			req_q <= req.data;
		if (cmd.issue) begin
			status_q <= issue_code;
			rdval_q  <= rf_rd;
			sel_st_q <= free_idx;
		end
		if (cmd.fetch1) begin
			st_tag1_q[sel_st_q] <= hit_idx;
			st_v1_q[sel_st_q]   <= fetch_val;
		end
		if (cmd.fetch2) begin
			st_tag2_q[sel_st_q] <= hit_idx;
			st_v2_q[sel_st_q]   <= fetch_val;
		end
		if (cmd.alloc) begin
			if (req_q.mode == MODE_W'(OP_LI)) begin
				st_v1_q[sel_st_q] <= req_q.immediate;
				st_v2_q[sel_st_q] <= '0;
			end
			st_op_q[sel_st_q]   <= req_q.mode;
			st_slot_q[sel_st_q] <= tail_q;
			rob_dest_q[tail_q]  <= req_q.target_reg;
		end
		if (cmd.ex_write)
			rob_val_q[st_slot_q[idx_q]] <= alu_res;
		if (cmd.bcast && take) begin
			if (half_q)
				st_v2_q[idx_q] <= rob_rd_val;
			else
				st_v1_q[idx_q] <= rob_rd_val;
		end
		if (cmd.commit) begin
			out_q.issue_status  <= status_q;
			out_q.commit_valid  <= c_ok;
			out_q.commit_reg    <= c_ok ? rob_dest_q[head_q] : '0;
			out_q.commit_value  <= c_ok ? rob_val_q[head_q] : '0;
			out_q.read_value    <= rdval_q;
			out_q.rob_occupancy <= OCC_W'(c_ok ? (count_q - 1'b1) : count_q);
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// result register still held this cycle
	assign stat.in_fire  = in_fire;
	assign stat.out_busy = out_valid_q & ~out_fire;
	assign stat.issue_ok = issue_ok;
	assign stat.is_li    = (req_q.mode == MODE_W'(OP_LI));
	assign stat.eligible = eligible;
	assign stat.alu_done = alu_done;
	assign stat.idx_last = idx_last;
	assign stat.half     = half_q;
endmodule
`default_nettype wire

// ----- design/ooo_rob_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ooo_rob_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ooo_rob_pkg::status_t stat,
	output ooo_rob_pkg::cmd_t         cmd
);
	import ooo_rob_pkg::*;

	ctrl_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE:     if (stat.in_fire) state_nx = S_ISSUE;
			S_ISSUE: begin
				if (!stat.issue_ok)
					state_nx = S_EX_CHECK;
				else if (stat.is_li)
					state_nx = S_ALLOC;
				else
					state_nx = S_FETCH1;
			end
			S_FETCH1:   state_nx = S_FETCH2;
			S_FETCH2:   state_nx = S_ALLOC;
			S_ALLOC:    state_nx = S_EX_CHECK;
			S_EX_CHECK: begin
				if (stat.eligible)
					state_nx = S_EX_WAIT;
				else if (stat.idx_last)
					state_nx = S_BCAST;
			end
			S_EX_WAIT: begin
				if (stat.alu_done)
					state_nx = stat.idx_last ? S_BCAST : S_EX_CHECK;
			end
			S_BCAST:    if (stat.idx_last && stat.half) state_nx = S_COMMIT;
			S_COMMIT:   if (!stat.out_busy) state_nx = S_IDLE;
			default:    state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:   cmd.in_ready = 1'b1;
			S_ISSUE: begin
				cmd.issue   = 1'b1;
				cmd.idx_clr = 1'b1;
			end
			S_FETCH1: cmd.fetch1 = 1'b1;
			S_FETCH2: cmd.fetch2 = 1'b1;
			S_ALLOC:  cmd.alloc  = 1'b1;
			S_EX_CHECK: begin
				cmd.ex_start = 1'b1;
				if (!stat.eligible) begin
					cmd.idx_clr = stat.idx_last;
					cmd.idx_inc = ~stat.idx_last;
				end
			end
			S_EX_WAIT: begin
				if (stat.alu_done) begin
					cmd.ex_write = 1'b1;
					cmd.idx_clr  = stat.idx_last;
					cmd.idx_inc  = ~stat.idx_last;
				end
			end
			S_BCAST:  cmd.bcast  = 1'b1;
			// hold the machine cycle's result until the last word has gone
			S_COMMIT: cmd.commit = ~stat.out_busy;
			default:  cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

// ----- design/out_of_order_rob_core_top.sv -----
`timescale 1ns / 1ps
// Per word: issue, two operand fetches (skipped for a load immediate) and allocate, all
// skipped when the word does not issue; then a check of each station in turn, where each
// ready station executes (add, sub, mul, load or divide); then operands are broadcast, and
// commit follows. The shared radix-2 divider sets the worst case. One word is processed at a
// time; the next can be taken in the cycle after commit, even while the last result waits.
// Reset: asynchronous, clears register file, ROB and station valid state and pointers.
`default_nettype none
module out_of_order_rob_core_top #(
	parameter int NUM_STATIONS = ooo_rob_pkg::DEF_NUM_STATIONS,
	parameter int ROB_DEPTH    = ooo_rob_pkg::DEF_ROB_DEPTH
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	ooo_rob_req_if.sink   req,
	ooo_rob_rsp_if.source rsp
);
	import ooo_rob_pkg::*;

	cmd_t    cmd;
	status_t stat;

	ooo_rob_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	ooo_rob_dp #(
		.NUM_STATIONS (NUM_STATIONS),
		.ROB_DEPTH    (ROB_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.stat   (stat)
	);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.data)))
		else $error("result word changed while waiting");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (int'(rsp.data.rob_occupancy) <= ROB_DEPTH))
		else $error("ROB occupancy out of range");

	a_no_commit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.data.commit_valid) |->
			(rsp.data.commit_reg == '0 && rsp.data.commit_value == '0))
		else $error("commit fields not cleared");

	a_single_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.issue, cmd.fetch1, cmd.fetch2, cmd.alloc, cmd.ex_write,
			cmd.bcast, cmd.commit}))
		else $error("conflicting datapath commands");
endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
	import ooo_rob_pkg::*;

	localparam int N_STN = 4;
	localparam int N_ROB = 4;
	localparam int N_RANDOM = 1530;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;

	ooo_rob_req_if req ();
	ooo_rob_rsp_if rsp ();

	out_of_order_rob_core_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	// machine state mirror
	logic [DATA_W-1:0] regs [NUM_REGS];
	logic [REG_W-1:0]  rb_dest [N_ROB];
	logic [DATA_W-1:0] rb_val [N_ROB];
	logic              rb_rdy [N_ROB];
	logic              rb_busy [N_ROB];
	logic [MODE_W-1:0] rs_op [N_STN];
	logic [1:0]        rs_tag1 [N_STN];
	logic [1:0]        rs_tag2 [N_STN];
	logic              rs_pend1 [N_STN];
	logic              rs_pend2 [N_STN];
	logic [DATA_W-1:0] rs_v1 [N_STN];
	logic [DATA_W-1:0] rs_v2 [N_STN];
	logic [1:0]        rs_slot [N_STN];
	logic              rs_busy [N_STN];
	int                head, tail, occ;

	rsp_word_t retire_q [$];
	bit        has_fixed [$];
	rsp_word_t fixed_q [$];

	int  mismatches;
	int  words_in, words_out, n_commits, n_div, n_stall;
	bit  hold_off;
	bit  sender_done;
	bit  all_in;

	function automatic logic [DATA_W-1:0] alu_result(logic [MODE_W-1:0] op,
			logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
		logic [DATA_W-1:0] ua, ub, q;
		case (op)
			OP_ADD: return a + b;
			OP_SUB: return a - b;
			OP_MUL: return a * b;
			OP_DIV: begin
				if (b == '0)
					return '0;
				ua = a[DATA_W-1] ? -a : a;
				ub = b[DATA_W-1] ? -b : b;
				q = ua / ub;
				return (a[DATA_W-1] != b[DATA_W-1]) ? -q : q;
			end
			default: return a;
		endcase
	endfunction

	task automatic lookup_operand(input logic [REG_W-1:0] r, output logic pend,
			output logic [1:0] tag, output logic [DATA_W-1:0] val);
		int idx;
		for (int k = 1; k <= occ; k++) begin
			idx = (tail + N_ROB - k) % N_ROB;
			if (rb_busy[idx] && rb_dest[idx] == r) begin
				pend = !rb_rdy[idx];
				tag = rb_rdy[idx] ? 2'd0 : idx[1:0];
				val = rb_rdy[idx] ? rb_val[idx] : '0;
				return;
			end
		end
		pend = 0;
		tag = 0;
		val = regs[r];
	endtask

	task automatic clear_machine();
		for (int i = 0; i < NUM_REGS; i++) regs[i] = '0;
		for (int i = 0; i < N_ROB; i++) begin
			rb_dest[i] = 0; rb_val[i] = 0; rb_rdy[i] = 0; rb_busy[i] = 0;
		end
		for (int i = 0; i < N_STN; i++) begin
			rs_op[i] = 0; rs_tag1[i] = 0; rs_tag2[i] = 0; rs_pend1[i] = 0;
			rs_pend2[i] = 0; rs_v1[i] = 0; rs_v2[i] = 0; rs_slot[i] = 0; rs_busy[i] = 0;
		end
		head = 0; tail = 0; occ = 0;
	endtask

	task automatic step_machine(input req_word_t w, output rsp_word_t r);
		int st, slot, h;
		r = '0;
		r.read_value = regs[w.read_reg];
		r.issue_status = ST_NONE;
		if (w.issue_valid && w.mode <= OP_LI) begin
			st = N_STN;
			for (int i = N_STN - 1; i >= 0; i--)
				if (!rs_busy[i]) st = i;
			if (occ >= N_ROB)
				r.issue_status = ST_ROB_FULL;
			else if (st == N_STN)
				r.issue_status = ST_RS_FULL;
			else begin
				slot = tail;
				if (w.mode == OP_LI) begin
					rs_pend1[st] = 0; rs_pend2[st] = 0; rs_tag1[st] = 0; rs_tag2[st] = 0;
					rs_v1[st] = w.immediate; rs_v2[st] = 0;
				end else begin
					lookup_operand(w.src1_reg, rs_pend1[st], rs_tag1[st], rs_v1[st]);
					lookup_operand(w.src2_reg, rs_pend2[st], rs_tag2[st], rs_v2[st]);
				end
				rs_op[st] = w.mode;
				rs_slot[st] = 2'(slot);
				rs_busy[st] = 1;
				rb_dest[slot] = w.target_reg;
				rb_val[slot] = 0;
				rb_rdy[slot] = 0;
				rb_busy[slot] = 1;
				tail = (slot + 1) % N_ROB;
				occ++;
				r.issue_status = ST_ISSUED;
			end
		end
		for (int i = 0; i < N_STN; i++)
			if (rs_busy[i] && !rs_pend1[i] && !rs_pend2[i]) begin
				rb_val[rs_slot[i]] = alu_result(rs_op[i], rs_v1[i], rs_v2[i]);
				rb_rdy[rs_slot[i]] = 1;
				rs_busy[i] = 0;
			end
		for (int i = 0; i < N_ROB; i++) begin
			if (!(rb_busy[i] && rb_rdy[i]))
				continue;
			for (int j = 0; j < N_STN; j++) begin
				if (!rs_busy[j])
					continue;
				if (rs_pend1[j] && rs_tag1[j] == i) begin
					rs_v1[j] = rb_val[i]; rs_pend1[j] = 0;
				end
				if (rs_pend2[j] && rs_tag2[j] == i) begin
					rs_v2[j] = rb_val[i]; rs_pend2[j] = 0;
				end
			end
		end
		h = head;
		if (rb_busy[h] && rb_rdy[h]) begin
			regs[rb_dest[h]] = rb_val[h];
			r.commit_valid = 1;
			r.commit_reg = rb_dest[h];
			r.commit_value = rb_val[h];
			rb_busy[h] = 0;
			rb_rdy[h] = 0;
			head = (h + 1) % N_ROB;
			if (occ > 0) occ--;
		end
		r.rob_occupancy = 3'(occ);
	endtask

	// directed rows: expected typed only where obvious
	typedef struct {
		req_word_t w;
		bit        fixed;
		rsp_word_t exp_r;
	} row_t;
	row_t dir_rows [$];

	function automatic req_word_t mk(bit v, logic [2:0] m, logic [2:0] d, logic [2:0] a,
			logic [2:0] b, logic [31:0] imm, logic [2:0] rr);
		req_word_t w;
		w.issue_valid = v; w.mode = m; w.target_reg = d; w.src1_reg = a;
		w.src2_reg = b; w.immediate = imm; w.read_reg = rr;
		return w;
	endfunction

	function automatic rsp_word_t mk_rsp(logic [1:0] s, bit cv, logic [2:0] cr,
			logic [31:0] cval, logic [31:0] rv, logic [2:0] o);
		rsp_word_t r;
		r.issue_status = s; r.commit_valid = cv; r.commit_reg = cr;
		r.commit_value = cval; r.read_value = rv; r.rob_occupancy = o;
		return r;
	endfunction

	task automatic add_row(req_word_t w);
		row_t x;
		x.w = w; x.fixed = 0; x.exp_r = '0;
		dir_rows.push_back(x);
	endtask

	task automatic add_fixed(req_word_t w, rsp_word_t r);
		row_t x;
		x.w = w; x.fixed = 1; x.exp_r = r;
		dir_rows.push_back(x);
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// ready only changes at the rising edge, so mid-cycle tells what the edge will see
	task automatic offer(req_word_t w, bit fixed, rsp_word_t r);
		rsp_word_t p;
		req.valid <= 1;
		req.data <= w;
		@(negedge clk);
		while (!req.ready) @(negedge clk);
		@(posedge clk);
		step_machine(w, p);
		retire_q.push_back(p);
		has_fixed.push_back(fixed);
		fixed_q.push_back(r);
		words_in++;
		if (w.issue_valid && w.mode == OP_DIV) n_div++;
	endtask

	task automatic idle_gap(int n);
		req.valid <= 0;
		repeat (n) @(posedge clk);
	endtask

	function automatic req_word_t rand_word(bit tight);
		req_word_t w;
		logic [31:0] imm;
		case ($urandom_range(0, 5))
			0: imm = 32'h8000_0000;
			1: imm = 32'hFFFF_FFFF;
			2: imm = 32'h7FFF_FFFF;
			3: imm = $urandom_range(0, 4);
			default: imm = $urandom;
		endcase
		w = mk($urandom_range(0, 9) != 0, ($urandom_range(0, 19) == 0) ?
			$urandom_range(5, 7) : $urandom_range(0, 4),
			$urandom_range(0, 7), tight ? $urandom_range(0, 2) : $urandom_range(0, 7),
			tight ? $urandom_range(0, 2) : $urandom_range(0, 7), imm, $urandom_range(0, 7));
		if (tight) w.target_reg = $urandom_range(0, 2);
		return w;
	endfunction

	initial begin
		rsp_word_t z;
		req_word_t w;
		int burst;
		z = '0;
		req.valid = 0;
		req.data = '0;
		arst_n = 0;
		all_in = 0;
		sender_done = 0;
		words_in = 0; n_div = 0;
		clear_machine();
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		add_fixed(mk(0, OP_ADD, 0, 0, 0, 0, 0), mk_rsp(ST_NONE, 0, 0, 0, 0, 0));
		add_fixed(mk(1, 3'd5, 1, 0, 0, 0, 7), mk_rsp(ST_NONE, 0, 0, 0, 0, 0));
		add_fixed(mk(1, 3'd7, 7, 7, 7, 32'hFFFF_FFFF, 3), mk_rsp(ST_NONE, 0, 0, 0, 0, 0));
		// load immediate issues, executes and commits within the same word
		add_fixed(mk(1, OP_LI, 1, 0, 0, 32'h8000_0000, 1),
			mk_rsp(ST_ISSUED, 1, 1, 32'h8000_0000, 0, 0));
		add_fixed(mk(1, OP_LI, 2, 0, 0, 32'hFFFF_FFFF, 1),
			mk_rsp(ST_ISSUED, 1, 2, 32'hFFFF_FFFF, 32'h8000_0000, 0));
		add_fixed(mk(1, OP_LI, 7, 0, 0, 32'h7FFF_FFFF, 7),
			mk_rsp(ST_ISSUED, 1, 7, 32'h7FFF_FFFF, 0, 0));
		// most negative / -1 wraps
		add_row(mk(1, OP_DIV, 3, 1, 2, 0, 3));
		// divide by zero
		add_row(mk(1, OP_DIV, 4, 7, 0, 0, 4));
		add_row(mk(1, OP_DIV, 5, 2, 7, 0, 5));
		add_row(mk(1, OP_ADD, 6, 7, 7, 0, 6));
		add_row(mk(1, OP_SUB, 6, 1, 7, 0, 6));
		add_row(mk(1, OP_MUL, 0, 7, 7, 0, 0));
		// dependent chain through the same register: youngest producer, forwarding
		add_row(mk(1, OP_LI, 3, 0, 0, 32'd5, 3));
		add_row(mk(1, OP_ADD, 3, 3, 3, 0, 3));
		add_row(mk(1, OP_MUL, 3, 3, 3, 0, 3));
		add_row(mk(1, OP_SUB, 4, 3, 2, 0, 4));
		add_row(mk(1, OP_DIV, 5, 4, 3, 0, 5));
		add_row(mk(1, OP_DIV, 5, 4, 2, 0, 2));
		add_row(mk(1, OP_ADD, 6, 5, 5, 0, 7));
		add_row(mk(1, OP_LI, 0, 0, 0, 32'h0, 0));
		add_row(mk(0, OP_LI, 0, 0, 0, 32'h0, 5));
		foreach (dir_rows[i])
			offer(dir_rows[i].w, dir_rows[i].fixed, dir_rows[i].exp_r);

		// let every outstanding word come back before the random part
		req.valid <= 0;
		wait (retire_q.size() == 0);
		@(posedge clk);

		// random, in bursts; sometimes long dependent runs to fill the ROB
		while (words_in < N_RANDOM + dir_rows.size()) begin
			burst = $urandom_range(1, 24);
			for (int i = 0; i < burst; i++) begin
				w = rand_word(words_in % 300 < 150);
				offer(w, 0, z);
			end
			if ($urandom_range(0, 2) == 0)
				idle_gap($urandom_range(1, 40));
			else if ($urandom_range(0, 60) == 0) begin
				req.valid <= 0;
				wait (retire_q.size() == 0);
				@(posedge clk);
			end
		end
		req.valid <= 0;
		all_in = 1;
	end

	// receiver: own stall pattern plus one long hold-off
	int rcv_cnt;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 0;
			rcv_cnt <= 0;
			hold_off <= 0;
		end else begin
			rcv_cnt <= rcv_cnt + 1;
			if (rcv_cnt == 300) hold_off <= 1;
			if (rcv_cnt == 1300) hold_off <= 0;
			if (hold_off)
				rsp.ready <= 0;
			else if ((rcv_cnt / 200) % 3 == 0)
				rsp.ready <= 1;
			else
				rsp.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		rsp_word_t e, a;
		bit f;
		rsp_word_t fx;
		if (arst_n && rsp.valid && rsp.ready) begin
			a = rsp.data;
			words_out++;
			if (retire_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word %p", a);
			end else begin
				e = retire_q.pop_front();
				f = has_fixed.pop_front();
				fx = fixed_q.pop_front();
				if (f && fx != e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("table row disagrees: table %p pred %p", fx, e);
				end
				if (a.commit_valid) n_commits++;
				if (a.issue_status inside {ST_ROB_FULL, ST_RS_FULL}) n_stall++;
				if (a !== e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch word %0d: exp %p got %p", words_out, e, a);
				end
			end
		end
	end

	int quiet;
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || hold_off)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("watchdog expired");
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		mismatches = 0; words_out = 0; n_commits = 0; n_stall = 0; quiet = 0;
		wait (all_in);
		wait (retire_q.size() == 0);
		repeat (200) @(posedge clk);
		$display("%0d words issued, %0d returned, %0d commits, %0d divides, %0d stalls",
			words_in, words_out, n_commits, n_div, n_stall);
		if (mismatches == 0 && retire_q.size() == 0)
			$display("simulation ok");
		else begin
			$display("%0d mismatches, %0d words outstanding", mismatches, retire_q.size());
			$display("simulation failed");
		end
		$finish;
	end
endmodule
